// File: rtl/palette_lookup_with_blend_modes_defines.svh
// ---------------------------------------------------------------------------
// Palette lookup assertion macros
// Shared concurrent assertion wrappers for the palette lookup block.
// ---------------------------------------------------------------------------
`ifndef PALETTE_LOOKUP_WITH_BLEND_MODES_DEFINES_SVH
`define PALETTE_LOOKUP_WITH_BLEND_MODES_DEFINES_SVH

// Check a property on every rising edge outside reset.
`define PLUT_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define PLUT_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/plut_pkg.sv
// ---------------------------------------------------------------------------
// Palette lookup package
// Shared widths, command and mode codes, and pipeline control type.
// ---------------------------------------------------------------------------
`default_nettype none

package plut_pkg;

    localparam int ENTRIES_DEFAULT = 256;
    localparam int CH_W            = 8;
    localparam int IDX_W           = 8;
    localparam int MODE_W          = 2;
    localparam int PIX_W           = 4 * CH_W;
    localparam int PADDR_W         = 3;
    localparam int PDATA_W         = 32;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    localparam logic [MODE_W-1:0] MODE_SOLID   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_TRANS   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LIGHT   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_DEFAULT = 2'd3;

    // Register index taken from the word address bit
    localparam logic REG_DEFAULT_MODE = 1'b0;

    typedef struct packed {
        logic              valid;
        logic              idx_nz;
        logic              in_range;
        logic [MODE_W-1:0] mode;
    } ctl_t;

endpackage

`default_nettype wire

// File: rtl/plut_item_if.sv
// ---------------------------------------------------------------------------
// Palette lookup item channel
// Valid/ready channel carrying one palette write or color read request.
// ---------------------------------------------------------------------------
`default_nettype none

interface plut_item_if;
    logic                              valid;
    logic                              ready;
    logic                              cmd;
    logic [plut_pkg::IDX_W-1:0]        index;
    logic [plut_pkg::CH_W-1:0]         in_red;
    logic [plut_pkg::CH_W-1:0]         in_green;
    logic [plut_pkg::CH_W-1:0]         in_blue;
    logic [plut_pkg::CH_W-1:0]         in_alpha;
    logic [plut_pkg::MODE_W-1:0]       mode;

    modport source (output valid, cmd, index, in_red, in_green, in_blue, in_alpha, mode,
                    input ready);
    modport sink   (input valid, cmd, index, in_red, in_green, in_blue, in_alpha, mode,
                    output ready);
endinterface

interface plut_result_if;
    logic                          valid;
    logic                          ready;
    logic [plut_pkg::CH_W-1:0]     out_red;
    logic [plut_pkg::CH_W-1:0]     out_green;
    logic [plut_pkg::CH_W-1:0]     out_blue;
    logic [plut_pkg::CH_W-1:0]     out_alpha;

    modport source (output valid, out_red, out_green, out_blue, out_alpha, input ready);
    modport sink   (input valid, out_red, out_green, out_blue, out_alpha, output ready);
endinterface

`default_nettype wire

// File: rtl/palette_lookup_with_blend_modes.sv
// ---------------------------------------------------------------------------
// Palette lookup with blend modes
// RGBA palette in a synchronous memory; reads return the entry solid,
// premultiplied, or as a black/white brightness overlay.
// ---------------------------------------------------------------------------
// Channel   Kind         Payload
// req       item sink    cmd, index, in_red, in_green, in_blue, in_alpha, mode
// rsp       result src   out_red, out_green, out_blue, out_alpha
// apb       config       default_mode at byte address 0
//
// One transaction per cycle while the pipeline advances; a read returns its
// color via the memory read, product and divide stages; writes return nothing.
// The whole pipeline advances when the output register is empty or taken, so
// rsp.ready reaches req.ready in the same cycle.
// rst_n clears control state only; palette contents are undefined until written.
`default_nettype none

`include "palette_lookup_with_blend_modes_defines.svh"

module palette_lookup_with_blend_modes #(
    parameter int ENTRIES = plut_pkg::ENTRIES_DEFAULT
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    plut_item_if.sink                          req,
    plut_result_if.source                      rsp,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [plut_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [plut_pkg::PDATA_W-1:0]  pwdata,
    output      logic [plut_pkg::PDATA_W-1:0]  prdata,
    output      logic                          pready
);

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    logic                        advance;
    logic                        accept;
    logic                        in_range;
    logic [plut_pkg::MODE_W-1:0] default_mode;
    logic [plut_pkg::MODE_W-1:0] mode_eff;
    logic [plut_pkg::PIX_W-1:0]  rd_data;
    logic [AW-1:0]               addr;
    plut_pkg::ctl_t              s1_ctl_reg;
    plut_pkg::ctl_t              s1_ctl_next;

    plut_cfg u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .default_mode (default_mode)
    );

    assign advance   = !rsp.valid || rsp.ready;
    assign req.ready = advance;
    assign accept    = req.valid && req.ready;
    assign in_range  = (32'(req.index) < ENTRIES);
    assign addr      = AW'(req.index);

    always_comb
    begin
        mode_eff = req.mode;
        if (req.mode == plut_pkg::MODE_DEFAULT)
        begin
            // A default register of 3 falls back to solid
            mode_eff = (default_mode == plut_pkg::MODE_DEFAULT) ? plut_pkg::MODE_SOLID
                                                                 : default_mode;
        end
        s1_ctl_next.valid    = accept && (req.cmd == plut_pkg::CMD_READ);
        s1_ctl_next.idx_nz   = (req.index != '0);
        s1_ctl_next.in_range = in_range;
        s1_ctl_next.mode     = mode_eff;
    end

    plut_mem #(
        .ENTRIES (ENTRIES),
        .AW      (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (accept && (req.cmd == plut_pkg::CMD_WRITE) && in_range),
        .wr_addr (addr),
        .wr_data ({req.in_alpha, req.in_blue, req.in_green, req.in_red}),
        .rd_en   (advance),
        .rd_addr (addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctl_reg <= '0;
        end
        else if (advance)
        begin
            s1_ctl_reg <= s1_ctl_next;
        end
    end

    plut_blend u_blend (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .ctl       (s1_ctl_reg),
        .entry     (rd_data),
        .res_valid (rsp.valid),
        .res_red   (rsp.out_red),
        .res_green (rsp.out_green),
        .res_blue  (rsp.out_blue),
        .res_alpha (rsp.out_alpha)
    );

    `PLUT_ASSERT(a_stall_blocks_input, clk, rst_n, (rsp.valid && !rsp.ready) |-> !req.ready, "input taken while result stalled")
    `PLUT_ASSERT(a_read_enters_pipe, clk, rst_n, (accept && (req.cmd == plut_pkg::CMD_READ)) |=> s1_ctl_reg.valid, "accepted read lost")
    `PLUT_ASSERT(a_write_no_result, clk, rst_n, (accept && (req.cmd == plut_pkg::CMD_WRITE)) |=> !s1_ctl_reg.valid, "write produced a result")
    `PLUT_ASSERT(a_stage_holds, clk, rst_n, (s1_ctl_reg.valid && !advance) |=> s1_ctl_reg.valid, "stalled read dropped")
    `PLUT_ASSERT_ALWAYS(a_mode_resolved, clk, s1_ctl_reg.valid |-> (s1_ctl_reg.mode != plut_pkg::MODE_DEFAULT), "default mode not resolved")

endmodule

`default_nettype wire

// File: rtl/plut_mem.sv
// ---------------------------------------------------------------------------
// Palette memory
// One write port, one read port, registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module plut_mem #(
    parameter int ENTRIES = plut_pkg::ENTRIES_DEFAULT,
    parameter int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  wire logic                       clk,
    input  wire logic                       wr_en,
    input  wire logic [AW-1:0]              wr_addr,
    input  wire logic [plut_pkg::PIX_W-1:0] wr_data,
    input  wire logic                       rd_en,
    input  wire logic [AW-1:0]              rd_addr,
    output      logic [plut_pkg::PIX_W-1:0] rd_data
);

    logic [plut_pkg::PIX_W-1:0] mem [ENTRIES];
    logic [plut_pkg::PIX_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Hold the read data while the pipeline is stalled
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: rtl/plut_cfg.sv
// ---------------------------------------------------------------------------
// Palette lookup configuration registers
// APB-style slave holding the default read mode.
// ---------------------------------------------------------------------------
`default_nettype none

module plut_cfg (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [plut_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [plut_pkg::PDATA_W-1:0]  pwdata,
    output      logic [plut_pkg::PDATA_W-1:0]  prdata,
    output      logic                          pready,
    output      logic [plut_pkg::MODE_W-1:0]   default_mode
);

    logic [plut_pkg::MODE_W-1:0] default_mode_reg;
    logic [plut_pkg::MODE_W-1:0] default_mode_next;
    logic                        reg_sel;

    assign reg_sel = paddr[2];
    assign pready  = 1'b1;

    always_comb
    begin
        default_mode_next = default_mode_reg;
        // Drop writes to addresses past the register list
        if (psel && penable && pwrite && pready && (reg_sel == plut_pkg::REG_DEFAULT_MODE))
        begin
            default_mode_next = pwdata[plut_pkg::MODE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            default_mode_reg <= plut_pkg::MODE_SOLID;
        end
        else
        begin
            default_mode_reg <= default_mode_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (reg_sel == plut_pkg::REG_DEFAULT_MODE)
        begin
            prdata = {{(plut_pkg::PDATA_W-plut_pkg::MODE_W){1'b0}}, default_mode_reg};
        end
    end

    assign default_mode = default_mode_reg;

endmodule

`default_nettype wire

// File: rtl/plut_blend.sv
// ---------------------------------------------------------------------------
// Palette lookup blend stages
// Two registered stages: products and brightness distance, then the divides
// by 255 and by 3 and the mode select into the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module plut_blend (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       advance,
    input  wire plut_pkg::ctl_t             ctl,
    input  wire logic [plut_pkg::PIX_W-1:0] entry,
    output      logic                       res_valid,
    output      logic [plut_pkg::CH_W-1:0]  res_red,
    output      logic [plut_pkg::CH_W-1:0]  res_green,
    output      logic [plut_pkg::CH_W-1:0]  res_blue,
    output      logic [plut_pkg::CH_W-1:0]  res_alpha
);

    localparam int CW = plut_pkg::CH_W;
    localparam int PW = 2 * CW;
    localparam int SW = CW + 3;     // holds 2*(r+g+b)
    localparam int VW = CW + 2;     // holds |2s - 765|
    localparam int QW = VW + 10;    // v * 683
    localparam logic [SW-1:0] MID = SW'(765);
    localparam logic [CW-1:0] HALF_ALPHA = CW'(128);
    localparam logic [CW-1:0] FULL = '1;

    // Stage one: read data to products
    logic [CW-1:0] r1, g1, b1, a1, ta1;
    logic [SW-1:0] s2x1;
    logic          dark1;
    logic [VW-1:0] v1;

    logic                    s2_valid_reg;
    logic [plut_pkg::MODE_W-1:0] s2_mode_reg;
    logic [PW-1:0]           s2_pr_reg, s2_pg_reg, s2_pb_reg;
    logic [CW-1:0]           s2_r_reg, s2_g_reg, s2_b_reg, s2_a_reg, s2_ta_reg;
    logic                    s2_dark_reg;
    logic [VW-1:0]           s2_v_reg;

    always_comb
    begin
        // Out-of-range reads act on an all-zero entry
        r1 = ctl.in_range ? entry[0*CW +: CW] : '0;
        g1 = ctl.in_range ? entry[1*CW +: CW] : '0;
        b1 = ctl.in_range ? entry[2*CW +: CW] : '0;
        a1 = ctl.in_range ? entry[3*CW +: CW] : '0;
        ta1 = ctl.idx_nz ? HALF_ALPHA : a1;
        s2x1 = SW'({3'b000, r1} + {3'b000, g1} + {3'b000, b1}) << 1;
        dark1 = (s2x1 < MID);
        v1 = dark1 ? VW'(MID - s2x1) : VW'(s2x1 - MID);
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s2_mode_reg <= ctl.mode;
            s2_pr_reg   <= PW'(r1 * ta1);
            s2_pg_reg   <= PW'(g1 * ta1);
            s2_pb_reg   <= PW'(b1 * ta1);
            s2_r_reg    <= r1;
            s2_g_reg    <= g1;
            s2_b_reg    <= b1;
            s2_a_reg    <= a1;
            s2_ta_reg   <= ta1;
            s2_dark_reg <= dark1;
            s2_v_reg    <= v1;
        end
    end

    // Stage two: divides and mode select
    function automatic logic [CW-1:0] div255(input logic [PW-1:0] p);
        logic [PW:0] t;
        begin
            t = {1'b0, p} + (PW+1)'(1) + (PW+1)'(p >> CW);
            div255 = t[CW +: CW];
        end
    endfunction

    logic [QW-1:0] q3;
    logic [CW-1:0] light_a;
    logic [CW-1:0] nr, ng, nb, na;

    always_comb
    begin
        q3 = QW'(s2_v_reg) * QW'(683);
        light_a = q3[11 +: CW];
        case (s2_mode_reg)
            plut_pkg::MODE_TRANS:
            begin
                nr = div255(s2_pr_reg);
                ng = div255(s2_pg_reg);
                nb = div255(s2_pb_reg);
                na = s2_ta_reg;
            end
            plut_pkg::MODE_LIGHT:
            begin
                nr = s2_dark_reg ? '0 : FULL;
                ng = s2_dark_reg ? '0 : FULL;
                nb = s2_dark_reg ? '0 : FULL;
                na = light_a;
            end
            default:
            begin
                nr = s2_r_reg;
                ng = s2_g_reg;
                nb = s2_b_reg;
                na = s2_a_reg;
            end
        endcase
    end

    logic          out_valid_reg;
    logic [CW-1:0] out_r_reg, out_g_reg, out_b_reg, out_a_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s2_valid_reg  <= ctl.valid;
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_r_reg <= nr;
            out_g_reg <= ng;
            out_b_reg <= nb;
            out_a_reg <= na;
        end
    end

    assign res_valid = out_valid_reg;
    assign res_red   = out_r_reg;
    assign res_green = out_g_reg;
    assign res_blue  = out_b_reg;
    assign res_alpha = out_a_reg;

endmodule

`default_nettype wire

// File: tb/palette_color_checker.sv
// ---------------------------------------------------------------------------
// Palette color checker
// Watches the request, result and register ports of the palette lookup,
// keeps its own copy of the palette and the default mode, predicts the color
// of every accepted read and compares each returned color field by field.
// ---------------------------------------------------------------------------
module palette_color_checker
    import plut_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    plut_item_if                    req,
    plut_result_if                  rsp,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    input  wire logic               pready,
    output int                      fail_count,
    output int                      pending
);

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] alpha;
    } color_t;

    color_t            palette_copy [ENTRIES_DEFAULT];
    color_t            color_q [$];
    logic [MODE_W-1:0] default_mode_reg = MODE_SOLID;
    int                errors = 0;

    assign fail_count = errors;

    function automatic color_t blend_color(input logic [IDX_W-1:0] idx,
                                           input logic [MODE_W-1:0] mode);
        color_t            c;
        logic [MODE_W-1:0] eff;
        int unsigned       a;
        int unsigned       s2;
        c   = palette_copy[idx];
        eff = (mode == MODE_DEFAULT) ? default_mode_reg : mode;
        case (eff)
            MODE_TRANS:
            begin
                // entry 0 keeps its own alpha, every other entry is half covered
                a       = (idx != '0) ? 128 : c.alpha;
                c.red   = CH_W'((c.red * a) / 255);
                c.green = CH_W'((c.green * a) / 255);
                c.blue  = CH_W'((c.blue * a) / 255);
                c.alpha = CH_W'(a);
            end
            MODE_LIGHT:
            begin
                s2 = 2 * (c.red + c.green + c.blue);
                if (s2 < 765)
                begin
                    c.red   = '0;
                    c.green = '0;
                    c.blue  = '0;
                    c.alpha = CH_W'((765 - s2) / 3);
                end
                else
                begin
                    c.red   = '1;
                    c.green = '1;
                    c.blue  = '1;
                    c.alpha = CH_W'((s2 - 765) / 3);
                end
            end
            default:
            begin
                // solid, and a default register holding the unused code
            end
        endcase
        return c;
    endfunction

    task automatic compare_color(input color_t want, input color_t got, output int bad);
        bad = 0;
        if (got.red !== want.red)
        begin
            $display("%0t: out_red mismatch: expected %0d actual %0d",
                     $time, want.red, got.red);
            bad++;
        end
        if (got.green !== want.green)
        begin
            $display("%0t: out_green mismatch: expected %0d actual %0d",
                     $time, want.green, got.green);
            bad++;
        end
        if (got.blue !== want.blue)
        begin
            $display("%0t: out_blue mismatch: expected %0d actual %0d",
                     $time, want.blue, got.blue);
            bad++;
        end
        if (got.alpha !== want.alpha)
        begin
            $display("%0t: out_alpha mismatch: expected %0d actual %0d",
                     $time, want.alpha, got.alpha);
            bad++;
        end
    endtask

    always @(posedge clk)
    begin
        color_t got;
        color_t want;
        int     bad;
        if (!rst_n)
        begin
            default_mode_reg <= MODE_SOLID;
            pending          <= 0;
        end
        else
        begin
            bad = 0;
            // check the outgoing transaction before queuing a new prediction
            if (rsp.valid && rsp.ready)
            begin
                got = {rsp.out_red, rsp.out_green, rsp.out_blue, rsp.out_alpha};
                if (color_q.size() == 0)
                begin
                    $display("%0t: unexpected color: expected none actual %h", $time, got);
                    bad = 1;
                end
                else
                begin
                    want = color_q.pop_front();
                    compare_color(want, got, bad);
                end
            end
            if (req.valid && req.ready)
            begin
                if (req.cmd == CMD_WRITE)
                    palette_copy[req.index] = {req.in_red, req.in_green,
                                               req.in_blue, req.in_alpha};
                else
                    color_q.push_back(blend_color(req.index, req.mode));
            end
            if (psel && penable && pwrite && pready && paddr == {REG_DEFAULT_MODE, 2'b00})
                default_mode_reg <= pwdata[MODE_W-1:0];
            errors  <= errors + bad;
            pending <= color_q.size();
        end
    end

endmodule

// File: tb/tb_top.sv
// ---------------------------------------------------------------------------
// Palette lookup testbench
// Writes palette entries and reads them back in every blend mode under each
// default mode setting, with bursty requests, a stalling result consumer and
// register writes between phases; a checker beside the block scores colors.
// ---------------------------------------------------------------------------
module tb_top;
    import plut_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE      = 8;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    int                 fail_count;
    int                 pending;

    plut_item_if   req_if ();
    plut_result_if rsp_if ();

    palette_lookup_with_blend_modes u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_if),
        .rsp     (rsp_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    palette_color_checker u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req_if),
        .rsp        (rsp_if),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pready     (pready),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    int cycle_count = 0;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // result consumer: random stall frames, plus long hold-offs on request
    int                 hold_req = 0;
    int                 hold_taken = 0;
    int                 hold_left = 0;
    int                 frame_left = 0;
    int                 stall_kind = 0;
    int                 frame_tick = 0;

    initial
    begin
        rsp_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left != 0)
            begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end
            else if (hold_taken != hold_req)
            begin
                hold_taken++;
                hold_left = HOLD_CYCLES;
                rsp_if.ready <= 1'b0;
            end
            else
            begin
                if (frame_left == 0)
                begin
                    frame_left = $urandom_range(16, 96);
                    stall_kind = $urandom_range(0, 3);
                end
                frame_left--;
                frame_tick++;
                case (stall_kind)
                    0:       rsp_if.ready <= 1'b1;
                    1:       rsp_if.ready <= ($urandom_range(0, 1) == 0);
                    2:       rsp_if.ready <= (frame_tick % 3 == 0);
                    default: rsp_if.ready <= ($urandom_range(0, 9) != 0);
                endcase
            end
        end
    end

    // request side state
    int         burst_left = 0;
    int         gap_max = 6;
    bit         written [ENTRIES_DEFAULT];
    logic [7:0] written_idx [$];

    task automatic offer(input logic cmd, input logic [IDX_W-1:0] idx,
                         input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
                         input logic [CH_W-1:0] b, input logic [CH_W-1:0] a,
                         input logic [MODE_W-1:0] mode);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            if (gap_max != 0 && $urandom_range(0, 3) != 0)
            begin
                req_if.valid <= 1'b0;
                repeat ($urandom_range(1, gap_max)) @(posedge clk);
            end
        end
        burst_left--;
        req_if.valid    <= 1'b1;
        req_if.cmd      <= cmd;
        req_if.index    <= idx;
        req_if.in_red   <= r;
        req_if.in_green <= g;
        req_if.in_blue  <= b;
        req_if.in_alpha <= a;
        req_if.mode     <= mode;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
    endtask

    task automatic send_write(input logic [IDX_W-1:0] idx, input logic [CH_W-1:0] r,
                              input logic [CH_W-1:0] g, input logic [CH_W-1:0] b,
                              input logic [CH_W-1:0] a);
        if (!written[idx])
        begin
            written[idx] = 1'b1;
            written_idx.push_back(idx);
        end
        offer(CMD_WRITE, idx, r, g, b, a, MODE_W'($urandom_range(0, 3)));
    endtask

    task automatic send_read(input logic [IDX_W-1:0] idx, input logic [MODE_W-1:0] mode);
        offer(CMD_READ, idx, CH_W'($urandom), CH_W'($urandom), CH_W'($urandom),
              CH_W'($urandom), mode);
    endtask

    function automatic logic [CH_W-1:0] rand_channel();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return CH_W'($urandom);
        endcase
    endfunction

    function automatic logic [IDX_W-1:0] pick_written();
        if ($urandom_range(0, 5) == 0)
            return '0;
        return written_idx[$urandom_range(0, written_idx.size() - 1)];
    endfunction

    task automatic random_read();
        send_read(pick_written(), MODE_W'($urandom_range(0, 3)));
    endtask

    task automatic random_traffic(input int count);
        logic [IDX_W-1:0] idx;
        repeat (count)
        begin
            if ($urandom_range(0, 9) < 3)
            begin
                idx = ($urandom_range(0, 3) == 0) ? pick_written()
                                                  : IDX_W'($urandom_range(0, 255));
                send_write(idx, rand_channel(), rand_channel(), rand_channel(),
                           rand_channel());
            end
            else
            begin
                random_read();
            end
        end
    endtask

    // drop valid, wait for every color, then let a trailing write leave the pipe
    task automatic drain();
        req_if.valid <= 1'b0;
        // let the last accepted transaction reach the pending count
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_default_mode(input logic [MODE_W-1:0] mode);
        drain();
        apb_write({REG_DEFAULT_MODE, 2'b00}, PDATA_W'(mode));
        repeat (2) @(posedge clk);
    endtask

    task automatic directed_items();
        // entry 0 with full alpha, then with zero alpha
        send_write(8'd0, 8'd200, 8'd100, 8'd50, 8'd255);
        send_read(8'd0, MODE_SOLID);
        send_read(8'd0, MODE_TRANS);
        send_write(8'd0, 8'd10, 8'd20, 8'd30, 8'd0);
        send_read(8'd0, MODE_TRANS);
        // all ones at the top index
        send_write(8'd255, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_read(8'd255, MODE_SOLID);
        send_read(8'd255, MODE_TRANS);
        send_read(8'd255, MODE_LIGHT);
        // all zeros: darkest overlay
        send_write(8'd1, 8'h00, 8'h00, 8'h00, 8'h00);
        send_read(8'd1, MODE_LIGHT);
        send_read(8'd1, MODE_TRANS);
        // brightness just below and just above the midpoint
        send_write(8'd2, 8'd127, 8'd127, 8'd128, 8'd77);
        send_read(8'd2, MODE_LIGHT);
        send_write(8'd3, 8'd128, 8'd127, 8'd128, 8'd33);
        send_read(8'd3, MODE_LIGHT);
        // default mode after reset
        send_write(8'd128, 8'h55, 8'hAA, 8'h55, 8'hAA);
        send_read(8'd128, MODE_DEFAULT);
        send_read(8'd128, MODE_TRANS);
        send_write(8'd127, 8'hAA, 8'h55, 8'hAA, 8'h55);
        send_read(8'd127, MODE_SOLID);
        send_read(8'd127, MODE_LIGHT);
        send_read(8'd0, MODE_DEFAULT);
    endtask

    initial
    begin
        req_if.valid    = 1'b0;
        req_if.cmd      = CMD_WRITE;
        req_if.index    = '0;
        req_if.in_red   = '0;
        req_if.in_green = '0;
        req_if.in_blue  = '0;
        req_if.in_alpha = '0;
        req_if.mode     = MODE_SOLID;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_items();

        set_default_mode(MODE_TRANS);
        random_traffic(270);
        // hold the consumer off while requests keep coming so the pipe backs up
        hold_req <= hold_req + 1;
        repeat (60) random_read();

        set_default_mode(MODE_LIGHT);
        random_traffic(270);

        set_default_mode(MODE_DEFAULT);
        gap_max = 0;
        random_traffic(270);
        hold_req <= hold_req + 1;
        repeat (40) random_read();

        set_default_mode(MODE_SOLID);
        gap_max = 10;
        random_traffic(230);

        set_default_mode(MODE_W'($urandom_range(0, 3)));
        gap_max = 4;
        random_traffic(230);

        drain();
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: palette_lookup_with_blend_modes.f
+incdir+rtl
rtl/plut_pkg.sv
rtl/plut_item_if.sv
rtl/plut_mem.sv
rtl/plut_cfg.sv
rtl/plut_blend.sv
rtl/palette_lookup_with_blend_modes.sv
tb/palette_color_checker.sv
tb/tb_top.sv
